@@ rtl/topk_expert_router_defines.svh @@
// Shared assertion macros for the expert router RTL.
`ifndef TOPK_EXPERT_ROUTER_DEFINES_SVH
`define TOPK_EXPERT_ROUTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TKR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TKR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tkr_pkg.sv @@
package tkr_pkg;

  localparam int MAX_KEPT    = 8;
  localparam int MAX_EXPERTS = 64;
  localparam int SCORE_W     = 16;
  localparam int IDX_W       = 6;
  localparam int CFG_W       = 4;
  localparam int KW          = $clog2(MAX_KEPT + 1);
  localparam int KI_W        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int POS_W       = $clog2(MAX_EXPERTS + 1);

  // batch snapshot queue, depth must be a power of two
  localparam int SQ_DEPTH = 2;
  localparam int SQ_AW    = (SQ_DEPTH > 1) ? $clog2(SQ_DEPTH) : 1;
  localparam int SQ_CW    = $clog2(SQ_DEPTH + 1);

  // config port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_TOP_COUNT = '0;

  typedef struct packed {
    logic [IDX_W-1:0]          expert;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    entry_t [MAX_KEPT-1:0] ent;
    logic [KW-1:0]         cnt;
  } snap_t;

  typedef struct packed {
    logic  vld;
    snap_t snap;
  } snap_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // top_count of 0 acts as 1, above MAX_KEPT clamps
  function automatic logic [KW-1:0] eff_k(input logic [CFG_W-1:0] tc);
    logic [KW-1:0] k;
    if (tc == '0) begin
      k = KW'(1);
    end else if (32'(tc) > MAX_KEPT) begin
      k = KW'(MAX_KEPT);
    end else begin
      k = KW'(tc);
    end
    return k;
  endfunction

endpackage

@@ rtl/tkr_front.sv @@
`include "topk_expert_router_defines.svh"

module tkr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic                          q_full_i,
  input  logic signed [15:0]            score_i,
  input  logic                          batch_end_i,
  input  logic [tkr_pkg::CFG_W-1:0]     top_count_i,
  output tkr_pkg::snap_wr_t             wr_o
);
  import tkr_pkg::*;

  entry_t [MAX_KEPT-1:0] ent_r, ent_nxt, ins, sh;
  logic [KW-1:0]         cnt_r, cnt_nxt, k_eff;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [MAX_KEPT-1:0]   live, ge, ge_up;
  logic                  accept, take, append;
  entry_t                new_e;

  always_comb begin
    accept       = push_i & ~q_full_i;
    k_eff        = eff_k(top_count_i);
    new_e.expert = IDX_W'(pos_r);
    new_e.score  = score_i;

    // ge is a prefix: entries at or above the new score stay put (ties keep order)
    for (int j = 0; j < MAX_KEPT; j++) begin
      live[j] = (KW'(j) < cnt_r);
      ge[j]   = live[j] && ($signed(ent_r[j].score) >= score_i);
    end
    ge_up[0] = 1'b1;
    sh[0]    = new_e;
    for (int j = 1; j < MAX_KEPT; j++) begin
      ge_up[j] = ge[j-1];
      sh[j]    = ent_r[j-1];
    end
    for (int j = 0; j < MAX_KEPT; j++) begin
      ins[j] = ge[j] ? ent_r[j] : (ge_up[j] ? new_e : sh[j]);
    end

    append = (cnt_r < k_eff);
    // full list: taken only if something live is strictly below the new score
    take   = (pos_r < POS_W'(MAX_EXPERTS)) && (append || |(live & ~ge));

    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (accept && (pos_r < POS_W'(MAX_EXPERTS))) begin
      pos_nxt = pos_r + 1'b1;
    end
    if (accept && take) begin
      ent_nxt = ins;
      if (append) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    wr_o.vld      = accept & batch_end_i;
    wr_o.snap.ent = ent_nxt;
    wr_o.snap.cnt = cnt_nxt;

    if (accept && batch_end_i) begin
      cnt_nxt = '0;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  `TKR_ASSERT_IMP(a_snap_nonempty, wr_o.vld, wr_o.snap.cnt != '0,
    "batch snapshot pushed with an empty list")
  `TKR_ASSERT_NXT(a_batch_clear, accept && batch_end_i, (cnt_r == '0) && (pos_r == '0),
    "batch state not cleared after batch end")

endmodule

@@ rtl/tkr_snap_q.sv @@
`include "topk_expert_router_defines.svh"

module tkr_snap_q (
  input  logic              clk,
  input  logic              rst_n,
  input  tkr_pkg::snap_wr_t wr_i,
  input  logic              rd_i,
  output tkr_pkg::snap_t    head_o,
  output tkr_pkg::q_stat_t  stat_o
);
  import tkr_pkg::*;

  snap_t            slot_r [SQ_DEPTH];
  logic [SQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [SQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    stat_o.empty = (cnt_r == '0);
    stat_o.full  = (cnt_r == SQ_CW'(SQ_DEPTH));
    head_o       = slot_r[rp_r];
    do_wr        = wr_i.vld & ~stat_o.full;
    do_rd        = rd_i & ~stat_o.empty;
    wp_nxt       = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt       = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt      = cnt_r;
    unique case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_i.snap;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `TKR_ASSERT_IMP(a_no_overflow, wr_i.vld, !stat_o.full,
    "snapshot written into a full queue")

endmodule

@@ rtl/tkr_back.sv @@
`include "topk_expert_router_defines.svh"

module tkr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tkr_pkg::snap_t                    head_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [tkr_pkg::IDX_W-1:0]         expert_index_o,
  output logic signed [tkr_pkg::SCORE_W-1:0] expert_score_o,
  output logic                              rank_last_o
);
  import tkr_pkg::*;

  logic                      valid_r;
  logic [KI_W-1:0]           idx_r;
  logic [IDX_W-1:0]          exp_r;
  logic signed [SCORE_W-1:0] score_r;
  logic                      last_r;
  logic                      load, drop, is_last;
  entry_t                    cur;

  always_comb begin
    cur     = head_i.ent[idx_r];
    is_last = ((KW+1)'(idx_r) + 1'b1) == {1'b0, head_i.cnt};
    drop    = ~q_empty_i && (head_i.cnt == '0);
    load    = ~q_empty_i && ~drop && (~valid_r || pop_i);
    q_pop_o = drop || (load && is_last);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      exp_r   <= cur.expert;
      score_r <= cur.score;
      last_r  <= is_last;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? '0 : idx_r + 1'b1;
      end else if (pop_i) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign empty_o        = ~valid_r;
  assign expert_index_o = exp_r;
  assign expert_score_o = score_r;
  assign rank_last_o    = last_r;

  `TKR_ASSERT_IMP(a_idx_in_list, !q_empty_i && (head_i.cnt != '0),
    (KW+1)'(idx_r) < {1'b0, head_i.cnt}, "read index past the end of the list")

endmodule

@@ rtl/topk_expert_router.sv @@
// Each score word is ranked into the kept list in the cycle it is accepted; while full is low,
// that is one word per cycle. The batch end writes the finished list into a two-deep queue;
// ranked words then load from it into the out_ registers, one per cycle while pop is high.
// full is high while two finished lists still wait to be read out.
// Synchronous active-low reset: list empty, position zero, queue and outputs empty, top_count 1.
module topk_expert_router (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [tkr_pkg::SCORE_W-1:0] in_score,
  input  logic                               in_batch_end,
  output logic                               empty,
  input  logic                               pop,
  output logic [tkr_pkg::IDX_W-1:0]          out_expert_index,
  output logic signed [tkr_pkg::SCORE_W-1:0] out_expert_score,
  output logic                               out_rank_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tkr_pkg::ADDR_W-1:0]         paddr,
  input  logic [tkr_pkg::DATA_W-1:0]         pwdata,
  output logic [tkr_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tkr_pkg::*;

  logic [CFG_W-1:0] top_count_r;
  logic             reg_hit, cfg_wr, q_pop;
  snap_wr_t         snap_wr;
  snap_t            head;
  q_stat_t          q_stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_TOP_COUNT);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? DATA_W'(top_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      top_count_r <= pwdata[CFG_W-1:0];
    end
  end

  assign full = q_stat.full;

  tkr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .q_full_i    (q_stat.full),
    .score_i     (in_score),
    .batch_end_i (in_batch_end),
    .top_count_i (top_count_r),
    .wr_o        (snap_wr)
  );

  tkr_snap_q u_snap_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (snap_wr),
    .rd_i   (q_pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  tkr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_i         (head),
    .q_empty_i      (q_stat.empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .expert_index_o (out_expert_index),
    .expert_score_o (out_expert_score),
    .rank_last_o    (out_rank_last)
  );

endmodule

@@ tb/topk_checker.sv @@
module topk_checker
  import tkr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      full,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic                      in_batch_end,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [IDX_W-1:0]          out_expert_index,
  input  logic signed [SCORE_W-1:0] out_expert_score,
  input  logic                      out_rank_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic                      pready,
  output int                        mismatches,
  output int                        outstanding,
  output int                        words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]          expert;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } ranked_word_t;

  ranked_word_t              ranked_words[$];
  logic [CFG_W-1:0]          top_count;
  logic [POS_W-1:0]          list_expert[MAX_KEPT];
  logic signed [SCORE_W-1:0] list_score[MAX_KEPT];
  int unsigned               list_len;
  int unsigned               position;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    words_checked = 0;
  end

  function automatic int unsigned kept_limit(input logic [CFG_W-1:0] tc);
    if (tc == '0) return 1;
    if (int'(tc) > MAX_KEPT) return MAX_KEPT;
    return int'(tc);
  endfunction

  function automatic void clear_list();
    for (int i = 0; i < MAX_KEPT; i++) begin
      list_expert[i] = '0;
      list_score[i]  = {1'b1, {(SCORE_W-1){1'b0}}};
    end
    list_len = 0;
    position = 0;
  endfunction

  // one swap pass from the tail up; a newcomer only moves past strictly lower scores
  function automatic void bubble_up();
    logic [POS_W-1:0]          te;
    logic signed [SCORE_W-1:0] ts;
    for (int i = list_len; i > 1; i--) begin
      if (list_score[i-1] > list_score[i-2]) begin
        te               = list_expert[i-1];
        ts               = list_score[i-1];
        list_expert[i-1] = list_expert[i-2];
        list_score[i-1]  = list_score[i-2];
        list_expert[i-2] = te;
        list_score[i-2]  = ts;
      end
    end
  endfunction

  function automatic void rank_score(input logic signed [SCORE_W-1:0] s, input logic closing);
    ranked_word_t w;
    if (position < MAX_EXPERTS) begin
      if (list_len < kept_limit(top_count)) begin
        list_expert[list_len] = POS_W'(position);
        list_score[list_len]  = s;
        list_len++;
      end else if (list_len != 0 && s > list_score[list_len-1]) begin
        // list full (or k lowered mid-batch): the tail entry is the one displaced
        list_expert[list_len-1] = POS_W'(position);
        list_score[list_len-1]  = s;
      end
      bubble_up();
      position++;
    end
    if (closing) begin
      for (int i = 0; i < list_len; i++) begin
        w.expert = list_expert[i][IDX_W-1:0];
        w.score  = list_score[i];
        w.last   = (i + 1 == list_len);
        ranked_words.push_back(w);
      end
      clear_list();
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: MISMATCH %s", $time, what);
  endfunction

  always @(posedge clk) begin
    ranked_word_t want;
    ranked_word_t got;
    if (!rst_n) begin
      top_count = CFG_W'(1);
      clear_list();
      ranked_words.delete();
    end else begin
      if (pop && !empty) begin
        got.expert = out_expert_index;
        got.score  = out_expert_score;
        got.last   = out_rank_last;
        words_checked++;
        if (ranked_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word idx=%0d score=%0d last=%0b",
                                  got.expert, got.score, got.last));
        end else begin
          want = ranked_words.pop_front();
          if (got.expert !== want.expert || got.score !== want.score ||
              got.last !== want.last) begin
            note_mismatch($sformatf("exp idx=%0d score=%0d last=%0b, got idx=%0d score=%0d last=%0b",
                                    want.expert, want.score, want.last,
                                    got.expert, got.score, got.last));
          end
        end
      end
      // a word taken at the same edge as a register write still sees the old top_count
      if (push && !full) rank_score(in_score, in_batch_end);
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_TOP_COUNT) begin
        top_count = pwdata[CFG_W-1:0];
      end
    end
    outstanding <= ranked_words.size();
  end

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkr_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 6;
  localparam logic [ADDR_W-1:0] TOP_COUNT_ADDR = {REG_TOP_COUNT, 2'b00};

  logic                      clk;
  logic                      rst_n        = 1'b0;
  logic                      push         = 1'b0;
  logic                      full;
  logic signed [SCORE_W-1:0] in_score     = '0;
  logic                      in_batch_end = 1'b0;
  logic                      empty;
  logic                      pop          = 1'b0;
  logic [IDX_W-1:0]          out_expert_index;
  logic signed [SCORE_W-1:0] out_expert_score;
  logic                      out_rank_last;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [ADDR_W-1:0]         paddr        = '0;
  logic [DATA_W-1:0]         pwdata       = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int mismatches;
  int outstanding;
  int words_checked;

  int send_idle = 26;
  int recv_idle = 48;
  int hold_due  = 0;
  int holds_done = 0;
  int scores_sent = 0;
  int batches_sent = 0;

  topk_expert_router u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_score         (in_score),
    .in_batch_end     (in_batch_end),
    .empty            (empty),
    .pop              (pop),
    .out_expert_index (out_expert_index),
    .out_expert_score (out_expert_score),
    .out_rank_last    (out_rank_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  topk_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_due > holds_done) begin
        holds_done++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic signed [SCORE_W-1:0] s, input logic closing);
    // each cycle idles on its own draw
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_score     <= s;
    in_batch_end <= closing;
    do @(posedge clk); while (full);
    scores_sent++;
    if (closing) batches_sent++;
  endtask

  task automatic send_scores(input int s[$], input logic closing);
    foreach (s[i]) send_word(SCORE_W'(s[i]), closing && (i == s.size() - 1));
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0:       return {1'b1, {(SCORE_W-1){1'b0}}};
      1:       return {1'b0, {(SCORE_W-1){1'b1}}};
      2, 3:    return SCORE_W'(int'($urandom_range(4)) - 2);  // ties
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_word(pick_score(), i == len - 1);
  endtask

  // stop pushing, wait until every expected word is out, then let in-flight scores settle
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_top_count(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOP_COUNT_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int k_set[6];
    int sent;
    int len;
    k_set = '{15, 3, 9, 1, 8, 6};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // k = 1 after reset: a later equal score must not displace the leader
    send_scores('{5, 100, 100, -32768}, 1'b1);
    wait_drained();
    write_top_count(8);
    send_scores('{-32768, 32767, 0, -1, 0, 32767}, 1'b1);
    send_scores('{1234}, 1'b1);
    wait_drained();
    // k lowered below the kept count in the middle of a batch
    send_scores('{300, -300, 7, 7, 50}, 1'b0);
    wait_drained();
    write_top_count(2);
    send_scores('{7, 400}, 1'b1);
    wait_drained();
    write_top_count(0);
    send_scores('{-1, -32768, 32767}, 1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_top_count(k_set[p]);
      case (p / 2)
        0: begin send_idle = 26; recv_idle = 48; end
        1: begin send_idle = 48; recv_idle = 26; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 4) hold_due++;
      // batch longer than the expert limit: tail scores are dropped
      if (p == 0) send_batch(MAX_EXPERTS + $urandom_range(1, 6));
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // short batches during the hold-off so finished lists pile up
        if (p == 4) len = $urandom_range(1, 2);
        else len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
        send_batch(len);
        sent += len;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d score words in %0d batches, top_count 0..15, one long hold-off",
             scores_sent, batches_sent);
    $display("%0d ranked words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tkr_pkg.sv
rtl/tkr_front.sv
rtl/tkr_snap_q.sv
rtl/tkr_back.sv
rtl/topk_expert_router.sv
tb/topk_checker.sv
tb/tb.sv
